// File: rtl/core/foc_cascade_svpwm_controller_macros.svh
// ----------------------------------------------------------------------------
// FOC cascade SVPWM controller assertion macros
// Concurrent check wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef FOC_CASCADE_SVPWM_CONTROLLER_MACROS_SVH
`define FOC_CASCADE_SVPWM_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define FCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define FCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FCS_ASSERT_IMP(lbl, ante, cons, msg)
`define FCS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/fcs_pkg.sv
// ----------------------------------------------------------------------------
// FOC cascade SVPWM controller package
// Payload types, register and state codes, fixed-point helpers.
// ----------------------------------------------------------------------------
package fcs_pkg;

  localparam int CordicIterations = 16;
  localparam int AtanEntries      = 24;
  localparam int GainFracBits     = 24;
  localparam int PW               = 72;

  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
  localparam logic signed [35:0] InvSqrt3Q15   = 36'sd18919;
  localparam logic signed [35:0] HalfSqrt3Q15  = 36'sd28378;
  localparam logic signed [35:0] Sqrt3Q15      = 36'sd56756;

  localparam logic [3:0] RegLoopMode     = 4'd0;
  localparam logic [3:0] RegPositionKp   = 4'd1;
  localparam logic [3:0] RegPositionKi   = 4'd2;
  localparam logic [3:0] RegVelocityKp   = 4'd3;
  localparam logic [3:0] RegVelocityKi   = 4'd4;
  localparam logic [3:0] RegCurrentKp    = 4'd5;
  localparam logic [3:0] RegCurrentKi    = 4'd6;
  localparam logic [3:0] RegPwmFullScale = 4'd7;

  localparam logic [1:0] ModePosition = 2'd0;
  localparam logic [1:0] ModeVelocity = 2'd1;
  localparam logic [1:0] ModeTorque   = 2'd2;
  localparam logic [1:0] ModeDisabled = 2'd3;

  localparam logic [1:0] IntegPos = 2'd0;
  localparam logic [1:0] IntegVel = 2'd1;
  localparam logic [1:0] IntegD   = 2'd2;
  localparam logic [1:0] IntegQ   = 2'd3;

  typedef logic signed [PW-1:0] wide_t;

  typedef struct packed {
    logic signed [15:0] phase_u_current;
    logic signed [15:0] phase_v_current;
    logic        [15:0] electrical_angle;
    logic signed [31:0] position_target;
    logic signed [31:0] velocity_target;
    logic signed [15:0] torque_target;
    logic signed [31:0] measured_position;
    logic signed [31:0] measured_velocity;
  } item_t;

  typedef struct packed {
    logic        [15:0] duty_u;
    logic        [15:0] duty_v;
    logic        [15:0] duty_w;
    logic        [2:0]  sector;
    logic signed [15:0] voltage_d;
    logic signed [15:0] voltage_q;
  } result_t;

  typedef struct packed {
    logic               re;
    logic        [1:0]  raddr;
    logic               we;
    logic        [1:0]  waddr;
    logic signed [31:0] wdata;
  } ram_req_t;

  typedef enum logic [5:0] {
    S_IDLE, S_CORDIC,
    S_B1, S_B2, S_B3, S_B4, S_B5, S_B6,
    S_P1, S_P2, S_P3, S_P4, S_P5,
    S_V1, S_V2, S_V3, S_V4, S_T1,
    S_C1, S_C2, S_C3, S_C4, S_C5, S_C6,
    S_I1, S_I2, S_I3, S_I4, S_I5,
    S_Z1, S_Z2, S_Z3, S_Z4, S_Z5, S_Z6, S_Z7, S_Z8,
    S_D1, S_D2, S_D3, S_D4, S_DONE
  } step_t;

  function automatic logic signed [15:0] sat16(input wide_t x);
    if (x > wide_t'(32767)) return 16'sh7fff;
    else if (x < wide_t'(-32768)) return 16'sh8000;
    else return x[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t x);
    if (x > wide_t'(64'sh7fffffff)) return 32'sh7fffffff;
    else if (x < -wide_t'(64'sh80000000)) return 32'sh80000000;
    else return x[31:0];
  endfunction

  function automatic wide_t rnd15(input wide_t x);
    return (x + wide_t'(16384)) >>> 15;
  endfunction

  function automatic logic signed [33:0] atan_entry(input logic [4:0] idx);
    case (idx)
      5'd0:  return 34'sh020000000;
      5'd1:  return 34'sh012E4051E;
      5'd2:  return 34'sh009FB385B;
      5'd3:  return 34'sh0051111D4;
      5'd4:  return 34'sh0028B0D43;
      5'd5:  return 34'sh00145D7E1;
      5'd6:  return 34'sh000A2F61E;
      5'd7:  return 34'sh000517C55;
      5'd8:  return 34'sh00028BE53;
      5'd9:  return 34'sh000145F2F;
      5'd10: return 34'sh0000A2F98;
      5'd11: return 34'sh0000517CC;
      5'd12: return 34'sh000028BE6;
      5'd13: return 34'sh0000145F3;
      5'd14: return 34'sh00000A2FA;
      5'd15: return 34'sh00000517D;
      5'd16: return 34'sh0000028BE;
      5'd17: return 34'sh00000145F;
      5'd18: return 34'sh000000A30;
      5'd19: return 34'sh000000518;
      5'd20: return 34'sh00000028C;
      5'd21: return 34'sh000000146;
      5'd22: return 34'sh0000000A3;
      5'd23: return 34'sh000000051;
      default: return '0;
    endcase
  endfunction

endpackage

// File: rtl/core/foc_cascade_svpwm_controller.sv
// ----------------------------------------------------------------------------
// FOC cascade SVPWM controller
// Clarke/Park, cascaded PI loops, inverse Park and SVPWM per PWM tick.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : one transaction per PWM tick with phase currents,
//                    electrical angle, targets and measured position and
//                    velocity; accepted when item_valid is high and
//                    item_stall is low.
//   result channel : duty counts, sector and d/q voltage commands; a
//                    transaction completes when result_valid is high and
//                    result_stall is low.
//   cfg channel    : register writes by index, cfg_ready is always high.
// Sequence: result_valid rises once the CORDIC, the steps on the one shared
//   multiplier (fewest in torque mode with a zero vector, most in position
//   mode) and the divider (only on overmodulation) are through. Disabled
//   mode goes from idle straight to the last step and loads from there.
// Throughput: one item at a time; item_stall is high from acceptance until
//   the result is moved into the output register, and the next item is
//   taken in the cycle after that.
// Reset: loads register defaults, clears the four integrators (via valid
//   bits, no clearing pass) and empties the output register.
// Stall: a result waits in the output register; the next item is still
//   accepted and computed, then holds in the last step until the slot frees.
// ----------------------------------------------------------------------------
`include "foc_cascade_svpwm_controller_macros.svh"

module foc_cascade_svpwm_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  fcs_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output fcs_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [3:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import fcs_pkg::*;

  // configuration registers
  logic [1:0]  loop_mode;
  logic [31:0] position_kp, position_ki, velocity_kp, velocity_ki;
  logic [31:0] current_kp, current_ki;
  logic [15:0] pwm_full_scale;

  step_t state, state_next;
  item_t itm;

  // datapath registers
  logic signed [15:0] c, s, beta, id, iq, tq, vd, vq;
  logic signed [31:0] err, vsp, intv, intd, intq;
  logic signed [16:0] ed, eq;
  logic signed [17:0] va, vb;
  logic signed [35:0] p, q, sv_b;
  logic [23:0]        t1, t2;
  logic [16:0]        f0, f1, f2;
  logic [15:0]        du, dv, dw;
  logic [2:0]         sect;
  wide_t              acc, prod;

  // shared multiplier operands
  logic signed [35:0] mul_a, mul_b;

  // combinational helpers
  logic               accept, load;
  logic               cordic_start, cordic_done, div_start, div_done;
  logic signed [15:0] cordic_cos, cordic_sin;
  logic [15:0]        div_quot;
  logic [24:0]        t_sum;
  logic [23:0]        t_round, h;
  wide_t              t_wide;
  logic signed [31:0] rd_data, int_add, int_sum;
  logic signed [35:0] sv [6];
  logic [2:0]         k_comb;
  logic               k_found;
  logic signed [35:0] sv_a_comb, sv_b_comb;
  ram_req_t           ram_req;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_mode      <= ModeDisabled;
      position_kp    <= 32'd167772160;
      position_ki    <= 32'd0;
      velocity_kp    <= 32'd1677722;
      velocity_ki    <= 32'd17;
      current_kp     <= 32'd8388608;
      current_ki     <= 32'd168;
      pwm_full_scale <= 16'd2000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegLoopMode:     loop_mode      <= cfg_data[1:0];
        RegPositionKp:   position_kp    <= cfg_data;
        RegPositionKi:   position_ki    <= cfg_data;
        RegVelocityKp:   velocity_kp    <= cfg_data;
        RegVelocityKi:   velocity_ki    <= cfg_data;
        RegCurrentKp:    current_kp     <= cfg_data;
        RegCurrentKi:    current_ki     <= cfg_data;
        RegPwmFullScale: pwm_full_scale <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  fcs_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   (item.electrical_angle),
    .done    (cordic_done),
    .cos_q15 (cordic_cos),
    .sin_q15 (cordic_sin)
  );

  fcs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (t1),
    .den   (t_sum),
    .done  (div_done),
    .quot  (div_quot)
  );

  fcs_integ_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // space-vector projections and sector search
  always_comb begin
    sv[0] = p <<< 1;
    sv[1] = p - q;
    sv[2] = -p - q;
    sv[3] = -sv[0];
    sv[4] = -sv[1];
    sv[5] = -sv[2];
    k_comb  = 3'd1;
    k_found = 1'b0;
    for (int m = 0; m < 6; m++) begin
      if (!k_found && sv[m] >= 0 && sv[(m == 5) ? 0 : m + 1] < 0) begin
        k_comb  = 3'(m + 1);
        k_found = 1'b1;
      end
    end
    case (k_comb)
      3'd1:    begin sv_a_comb = sv[0]; sv_b_comb = sv[1]; end
      3'd2:    begin sv_a_comb = sv[1]; sv_b_comb = sv[2]; end
      3'd3:    begin sv_a_comb = sv[2]; sv_b_comb = sv[3]; end
      3'd4:    begin sv_a_comb = sv[3]; sv_b_comb = sv[4]; end
      3'd5:    begin sv_a_comb = sv[4]; sv_b_comb = sv[5]; end
      default: begin sv_a_comb = sv[5]; sv_b_comb = sv[0]; end
    endcase
  end

  // dwell time rounding, clamp negative to zero
  always_comb begin
    t_wide  = (prod + (wide_t'(1) <<< 29)) >>> 30;
    t_round = (t_wide < 0) ? '0 : 24'(t_wide);
    t_sum   = 25'(t1) + 25'(t2);
    h       = 24'((25'd32768 - 25'(t1) - 25'(t2)) >> 1);
  end

  // integrator update value
  always_comb begin
    case (state)
      S_C2:    int_add = 32'(ed);
      S_C3:    int_add = 32'(eq);
      default: int_add = err;
    endcase
    int_sum = sat32(wide_t'(rd_data) + wide_t'(int_add));
  end

  // sequencer: next step, multiplier operands, memory requests
  always_comb begin
    state_next   = state;
    mul_a        = '0;
    mul_b        = '0;
    cordic_start = 1'b0;
    div_start    = 1'b0;
    load         = 1'b0;
    ram_req      = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (loop_mode == ModeDisabled) begin
            state_next = S_DONE;
          end else begin
            cordic_start = 1'b1;
            state_next   = S_CORDIC;
          end
        end
      end
      S_CORDIC: if (cordic_done) state_next = S_B1;
      S_B1: begin
        mul_a = 36'(itm.phase_u_current) + (36'(itm.phase_v_current) <<< 1);
        mul_b = InvSqrt3Q15;
        state_next = S_B2;
      end
      S_B2: begin
        mul_a = 36'(itm.phase_u_current);
        mul_b = 36'(c);
        state_next = S_B3;
      end
      S_B3: begin
        mul_a = 36'(beta);
        mul_b = 36'(s);
        state_next = S_B4;
      end
      S_B4: begin
        mul_a = -36'(itm.phase_u_current);
        mul_b = 36'(s);
        state_next = S_B5;
      end
      S_B5: begin
        mul_a = 36'(beta);
        mul_b = 36'(c);
        state_next = S_B6;
      end
      S_B6: begin
        case (loop_mode)
          ModePosition: state_next = S_P1;
          ModeVelocity: state_next = S_V1;
          default:      state_next = S_T1;
        endcase
      end
      S_P1: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = IntegPos;
        state_next    = S_P2;
      end
      S_P2: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = IntegPos;
        ram_req.wdata = int_sum;
        mul_a = 36'(err);
        mul_b = signed'(36'(position_kp));
        state_next = S_P3;
      end
      S_P3: begin
        mul_a = 36'(intv);
        mul_b = signed'(36'(position_ki));
        state_next = S_P4;
      end
      S_P4: state_next = S_P5;
      S_P5, S_V1: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = IntegVel;
        state_next    = S_V2;
      end
      S_V2: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = IntegVel;
        ram_req.wdata = int_sum;
        mul_a = 36'(err);
        mul_b = signed'(36'(velocity_kp));
        state_next = S_V3;
      end
      S_V3: begin
        mul_a = 36'(intv);
        mul_b = signed'(36'(velocity_ki));
        state_next = S_V4;
      end
      S_V4, S_T1: state_next = S_C1;
      S_C1: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = IntegD;
        state_next    = S_C2;
      end
      S_C2: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = IntegD;
        ram_req.wdata = int_sum;
        ram_req.re    = 1'b1;
        ram_req.raddr = IntegQ;
        mul_a = 36'(ed);
        mul_b = signed'(36'(current_kp));
        state_next = S_C3;
      end
      S_C3: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = IntegQ;
        ram_req.wdata = int_sum;
        mul_a = 36'(intd);
        mul_b = signed'(36'(current_ki));
        state_next = S_C4;
      end
      S_C4: begin
        mul_a = 36'(eq);
        mul_b = signed'(36'(current_kp));
        state_next = S_C5;
      end
      S_C5: begin
        mul_a = 36'(intq);
        mul_b = signed'(36'(current_ki));
        state_next = S_C6;
      end
      S_C6: state_next = S_I1;
      S_I1: begin
        mul_a = 36'(vd);
        mul_b = 36'(c);
        state_next = S_I2;
      end
      S_I2: begin
        mul_a = 36'(vq);
        mul_b = 36'(s);
        state_next = S_I3;
      end
      S_I3: begin
        mul_a = 36'(vd);
        mul_b = 36'(s);
        state_next = S_I4;
      end
      S_I4: begin
        mul_a = 36'(vq);
        mul_b = 36'(c);
        state_next = S_I5;
      end
      S_I5: state_next = S_Z1;
      S_Z1: begin
        mul_a = 36'(va);
        mul_b = HalfSqrt3Q15;
        if (va <= 18'sd3 && va >= -18'sd3 && vb <= 18'sd3 && vb >= -18'sd3) begin
          state_next = S_D1;
        end else begin
          state_next = S_Z2;
        end
      end
      S_Z2: state_next = S_Z3;
      S_Z3: begin
        mul_a = sv_a_comb;
        mul_b = Sqrt3Q15;
        state_next = S_Z4;
      end
      S_Z4: begin
        mul_a = -sv_b;
        mul_b = Sqrt3Q15;
        state_next = S_Z5;
      end
      S_Z5: state_next = S_Z6;
      S_Z6: begin
        if (t_sum > 25'd32768) begin
          div_start  = 1'b1;
          state_next = S_Z7;
        end else begin
          state_next = S_Z8;
        end
      end
      S_Z7: if (div_done) state_next = S_Z8;
      S_Z8: state_next = S_D1;
      S_D1: begin
        mul_a = signed'(36'(f0));
        mul_b = signed'(36'(pwm_full_scale));
        state_next = S_D2;
      end
      S_D2: begin
        mul_a = signed'(36'(f1));
        mul_b = signed'(36'(pwm_full_scale));
        state_next = S_D3;
      end
      S_D3: begin
        mul_a = signed'(36'(f2));
        mul_b = signed'(36'(pwm_full_scale));
        state_next = S_D4;
      end
      S_D4: state_next = S_DONE;
      S_DONE: begin
        // hold until the output register is free
        if (!result_valid || !result_stall) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // datapath updates, one step per state
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          itm <= item;
          // disabled mode: half duty, zero vector, integrators hold
          du   <= pwm_full_scale >> 1;
          dv   <= pwm_full_scale >> 1;
          dw   <= pwm_full_scale >> 1;
          sect <= 3'd0;
          vd   <= '0;
          vq   <= '0;
        end
      end
      S_CORDIC: begin
        if (cordic_done) begin
          c <= cordic_cos;
          s <= cordic_sin;
        end
      end
      S_B2: beta <= sat16(rnd15(prod));
      S_B3, S_B5, S_I2, S_I4: acc <= prod;
      S_B4: id <= sat16(rnd15(acc + prod));
      S_B6: iq <= sat16(rnd15(acc + prod));
      S_P1: err <= sat32(wide_t'(itm.position_target) - wide_t'(itm.measured_position));
      S_P2, S_V2: intv <= int_sum;
      S_P3, S_C3, S_C5: acc <= prod >>> GainFracBits;
      S_P4: vsp <= sat32(acc + (prod >>> GainFracBits));
      S_P5: err <= sat32(wide_t'(vsp) - wide_t'(itm.measured_velocity));
      S_V1: err <= sat32(wide_t'(itm.velocity_target) - wide_t'(itm.measured_velocity));
      S_V3: acc <= prod >>> (GainFracBits + 1);
      S_V4: tq <= sat16(acc + (prod >>> (GainFracBits + 1)));
      S_T1: tq <= itm.torque_target;
      S_C1: begin
        ed <= -17'(id);
        eq <= 17'(tq) - 17'(iq);
      end
      S_C2: intd <= int_sum;
      S_C4: begin
        vd   <= sat16(acc + (prod >>> GainFracBits));
      end
      S_C6: vq <= sat16(acc + (prod >>> GainFracBits));
      S_I3: va <= 18'(rnd15(acc - prod));
      S_I5: vb <= 18'(rnd15(acc + prod));
      S_Z1: begin
        p    <= 36'(vb) <<< 14;
        f0   <= 17'd16384;
        f1   <= 17'd16384;
        f2   <= 17'd16384;
        sect <= 3'd0;
      end
      S_Z2: q <= 36'(prod);
      S_Z3: begin
        sect <= k_comb;
        sv_b <= sv_b_comb;
      end
      S_Z4: t2 <= t_round;
      S_Z5: t1 <= t_round;
      S_Z7: begin
        if (div_done) begin
          t1 <= 24'(div_quot);
          t2 <= 24'd32768 - 24'(div_quot);
        end
      end
      S_Z8: begin
        case (sect)
          3'd1: begin
            f0 <= 17'(t1 + t2 + h); f1 <= 17'(t2 + h); f2 <= 17'(h);
          end
          3'd2: begin
            f0 <= 17'(t1 + h); f1 <= 17'(t1 + t2 + h); f2 <= 17'(h);
          end
          3'd3: begin
            f0 <= 17'(h); f1 <= 17'(t1 + t2 + h); f2 <= 17'(t2 + h);
          end
          3'd4: begin
            f0 <= 17'(h); f1 <= 17'(t1 + h); f2 <= 17'(t1 + t2 + h);
          end
          3'd5: begin
            f0 <= 17'(t2 + h); f1 <= 17'(h); f2 <= 17'(t1 + t2 + h);
          end
          default: begin
            f0 <= 17'(t1 + t2 + h); f1 <= 17'(h); f2 <= 17'(t1 + h);
          end
        endcase
      end
      S_D2: du <= prod[30:15];
      S_D3: dv <= prod[30:15];
      S_D4: dw <= prod[30:15];
      default: ;
    endcase
  end

  // the store takes the Q integrator write at S_C3; intd was captured at S_C2
  always_ff @(posedge clk) begin
    if (state == S_C3) begin
      intq <= int_sum;
    end
  end

  // output register decouples the result side from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.duty_u    <= du;
      result.duty_v    <= dv;
      result.duty_w    <= dw;
      result.sector    <= sect;
      result.voltage_d <= vd;
      result.voltage_q <= vq;
    end
  end

  `FCS_ASSERT_NXT(a_busy_after_accept, accept, item_stall, "not busy after accepting an item")
  `FCS_ASSERT_IMP(a_idle_no_write, state == S_IDLE, !ram_req.we, "integrator write while idle")
  `FCS_ASSERT_IMP(a_cordic_done_state, cordic_done, state == S_CORDIC, "CORDIC done out of step")
  `FCS_ASSERT_IMP(a_ram_no_collide, ram_req.we && ram_req.re, ram_req.waddr != ram_req.raddr, "same-entry read and write")

endmodule

// File: rtl/core/fcs_integ_ram.sv
// ----------------------------------------------------------------------------
// Integrator store
// Four-entry synchronous RAM, registered read, entries read as zero
// until first written after reset.
// ----------------------------------------------------------------------------
module fcs_integ_ram (
  input  logic               clk,
  input  logic               rst,
  input  fcs_pkg::ram_req_t  req,
  output logic signed [31:0] rd_data
);
  import fcs_pkg::*;

  logic signed [31:0] mem [4];
  logic [3:0]         written;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= written[req.raddr] ? mem[req.raddr] : '0;
    end
  end

  // valid bits stand in for the zero reset of the array
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.we) begin
      written[req.waddr] <= 1'b1;
    end
  end

endmodule

// File: rtl/core/fcs_cordic.sv
// ----------------------------------------------------------------------------
// Iterative CORDIC
// One rotation step per cycle; gives Q1.15 sine and cosine of a
// 16-bit angle.
// ----------------------------------------------------------------------------
module fcs_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic        [15:0] angle,
  output logic               done,
  output logic signed [15:0] cos_q15,
  output logic signed [15:0] sin_q15
);
  import fcs_pkg::*;

  localparam int Steps = (CordicIterations < AtanEntries) ? CordicIterations : AtanEntries;
  localparam int IW    = $clog2(Steps);
  localparam int AW    = $clog2(AtanEntries);
  localparam logic [IW-1:0] LastIter = IW'(Steps - 1);

  logic               busy;
  logic [IW-1:0]      iter;
  logic signed [33:0] x, y, z;
  logic               flip;
  logic signed [33:0] z0, z_raw, x_f, y_f, x_r, y_r, atan_v;
  logic               flip0;

  always_comb begin
    z_raw = 34'(signed'({angle, 16'h0000}));
    z0    = z_raw;
    flip0 = 1'b0;
    if (z_raw > 34'sh040000000) begin
      z0    = z_raw - 34'sh080000000;
      flip0 = 1'b1;
    end else if (z_raw < -34'sh040000000) begin
      z0    = z_raw + 34'sh080000000;
      flip0 = 1'b1;
    end
    atan_v = atan_entry(AW'(iter));
    x_f    = flip ? -x : x;
    y_f    = flip ? -y : y;
    x_r    = (x_f + 34'sd16384) >>> 15;
    y_r    = (y_f + 34'sd16384) >>> 15;
    if (x_r > 34'sd32767) cos_q15 = 16'sd32767;
    else if (x_r < -34'sd32767) cos_q15 = -16'sd32767;
    else cos_q15 = x_r[15:0];
    if (y_r > 34'sd32767) sin_q15 = 16'sd32767;
    else if (y_r < -34'sd32767) sin_q15 = -16'sd32767;
    else sin_q15 = y_r[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && iter == LastIter) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CordicGainQ30;
      y    <= '0;
      z    <= z0;
      flip <= flip0;
      iter <= '0;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - (y >>> iter);
        y <= y + (x >>> iter);
        z <= z - atan_v;
      end else begin
        x <= x + (y >>> iter);
        y <= y - (x >>> iter);
        z <= z + atan_v;
      end
      iter <= iter + 1'b1;
    end
  end

endmodule

// File: rtl/core/fcs_div.sv
// ----------------------------------------------------------------------------
// Overmodulation divider
// Restoring division of num * 32768 by den for num <= den, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] num,
  input  logic [24:0] den,
  output logic        done,
  output logic [15:0] quot
);
  import fcs_pkg::*;

  logic        busy;
  logic [3:0]  cnt;
  logic [25:0] rem, rem2;
  logic [24:0] den_r;

  assign rem2 = {rem[24:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 4'd14) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      cnt   <= '0;
      // integer part is one only when num equals den
      if (25'(num) >= den) begin
        rem  <= 26'(25'(num) - den);
        quot <= 16'd1;
      end else begin
        rem  <= 26'(num);
        quot <= 16'd0;
      end
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (rem2 >= 26'(den_r)) begin
        rem  <= rem2 - 26'(den_r);
        quot <= {quot[14:0], 1'b1};
      end else begin
        rem  <= rem2;
        quot <= {quot[14:0], 1'b0};
      end
    end
  end

endmodule
